// ===== hdl/priority_queue_fifo_ties_macros.svh =====
// Assertion macros for the priority queue checker
`ifndef PRIORITY_QUEUE_FIFO_TIES_MACROS_SVH
`define PRIORITY_QUEUE_FIFO_TIES_MACROS_SVH

// same-cycle implication
`define PQFT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pqft check failed");

// next-cycle implication
`define PQFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pqft check failed");

`endif

// ===== hdl/pqft_pkg.sv =====
// Types and codes shared by the priority queue cells, top level and checker
package pqft_pkg;

    localparam logic [2:0] FN_PUSH_HEAD = 3'd0;
    localparam logic [2:0] FN_PUSH_PRIO = 3'd1;
    localparam logic [2:0] FN_POP       = 3'd2;
    localparam logic [2:0] FN_FIND      = 3'd3;
    localparam logic [2:0] FN_REMOVE    = 3'd4;
    localparam logic [2:0] FN_CLEAR     = 3'd5;
    localparam logic [2:0] FN_RSVD_6    = 3'd6;
    localparam logic [2:0] FN_RSVD_7    = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] tag;
        logic [7:0]  prio_in;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] tag_out;
        logic [7:0]  prio_out;
        logic [4:0]  count;
    } t_out;

    typedef struct packed {
        logic load;
        logic from_prev;
        logic from_next;
    } t_cell_ctl;

endpackage

// ===== hdl/pqft_cell.sv =====
// One queue slot: holds an entry, compares it with the key, shifts to/from neighbours
module pqft_cell (
    input  logic                  i_clk,
    input  logic                  i_cmp_en,
    input  logic [15:0]           i_key_tag,
    input  logic [7:0]            i_key_prio,
    input  pqft_pkg::t_cell_ctl   i_ctl,
    input  logic [15:0]           i_new_tag,
    input  logic [7:0]            i_new_prio,
    input  logic [15:0]           i_prev_tag,
    input  logic [7:0]            i_prev_prio,
    input  logic [15:0]           i_next_tag,
    input  logic [7:0]            i_next_prio,
    output logic [15:0]           o_tag,
    output logic [7:0]            o_prio,
    output logic                  o_le,
    output logic                  o_eq
);

    logic [15:0] r_tag;
    logic [7:0]  r_prio;
    logic        r_le;
    logic        r_eq;
    logic [15:0] n_tag;
    logic [7:0]  n_prio;

    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_ctl.load) begin
            n_tag  = i_new_tag;
            n_prio = i_new_prio;
        end else if (i_ctl.from_prev) begin
            n_tag  = i_prev_tag;
            n_prio = i_prev_prio;
        end else if (i_ctl.from_next) begin
            n_tag  = i_next_tag;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
        if (i_cmp_en) begin
            r_le <= (r_prio <= i_key_prio);
            r_eq <= (r_tag == i_key_tag);
        end
    end

    assign o_tag  = r_tag;
    assign o_prio = r_prio;
    assign o_le   = r_le;
    assign o_eq   = r_eq;

endmodule

// ===== hdl/priority_queue_fifo_ties.sv =====
// Top level of the ordered (tag, priority) queue built from a chain of slot cells
//
// Input channel i_in_*: one operation per transfer (push head, push by priority,
// pop, find, remove, clear). Output channel o_out_*: exactly one result per
// operation, in order, carrying status, entry tag/priority and the new count.
// On the input transfer every cell registers the compare of its entry with the
// key; once the output register is free, the first-hit position is resolved and
// all cells shift, load or hold at once while the result is registered.
// A new operation is not taken until the one in flight has finished;
// o_in_stall is high while an operation is in flight.
// A finished result sits in the output register until taken; if it is still
// stalled when the next operation completes, that operation waits in the
// chain and the input stays stalled.
// Reset empties the queue (count 0) and drops any pending result; slot
// contents are left as they are. o_in_stall is high during reset.
// Pop returns the tail entry: smallest priority first, equal priorities FIFO.
module priority_queue_fifo_ties #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  pqft_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output pqft_pkg::t_out  o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                r_busy;
    pqft_pkg::t_in       r_cmd;
    logic [CW-1:0]       r_count;
    logic                r_out_valid;
    pqft_pkg::t_out      r_out;

    logic [CW-1:0]       n_count;
    pqft_pkg::t_out      n_out;

    logic                in_xfer;
    logic                finish;
    logic [DEPTH-1:0]    occ;
    logic [DEPTH-1:0]    le_v;
    logic [DEPTH-1:0]    eq_v;
    logic [DEPTH-1:0]    ins_h;
    logic [DEPTH-1:0]    find_h;
    logic [DEPTH-1:0]    sel_h;
    logic [DEPTH-1:0]    first;
    logic [DEPTH-1:0]    below;
    logic [DEPTH-1:0]    tail;
    logic [DEPTH-1:0]    rd_sel;
    logic [15:0]         rd_tag;
    logic [7:0]          rd_prio;
    logic                full;
    logic                empty;
    logic                found;
    logic                do_ins;
    logic                do_rem;
    logic [7:0]          new_prio;
    logic [CW+4:0]       cnt_ext;

    logic [15:0]         cell_tag  [DEPTH];
    logic [7:0]          cell_prio [DEPTH];
    pqft_pkg::t_cell_ctl cell_ctl  [DEPTH];

    assign o_in_stall = r_busy || !i_rst_n;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign finish     = r_busy && (!r_out_valid || !i_out_stall);

    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign find_h = eq_v & occ;
    assign found  = |find_h;
    assign ins_h  = (r_cmd.func == pqft_pkg::FN_PUSH_HEAD) ? DEPTH'(1) : (le_v | ~occ);
    assign sel_h  = (r_cmd.func == pqft_pkg::FN_FIND || r_cmd.func == pqft_pkg::FN_REMOVE)
                    ? find_h : ins_h;
    assign first  = sel_h & (~sel_h + DEPTH'(1));
    assign below  = first - DEPTH'(1);
    assign tail   = occ & ~(occ >> 1);
    assign rd_sel = (r_cmd.func == pqft_pkg::FN_POP) ? tail : first;
    assign new_prio = (r_cmd.func == pqft_pkg::FN_PUSH_HEAD) ? 8'd0 : r_cmd.prio_in;

    always_comb begin
        rd_tag  = '0;
        rd_prio = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_tag  = rd_tag  | (cell_tag[i]  & {16{rd_sel[i]}});
            rd_prio = rd_prio | (cell_prio[i] & {8{rd_sel[i]}});
        end
    end

    always_comb begin
        n_count        = r_count;
        do_ins         = 1'b0;
        do_rem         = 1'b0;
        n_out.status   = pqft_pkg::ST_OK;
        n_out.tag_out  = '0;
        n_out.prio_out = '0;
        case (r_cmd.func)
            pqft_pkg::FN_PUSH_HEAD, pqft_pkg::FN_PUSH_PRIO: begin
                if (full) begin
                    n_out.status = pqft_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            pqft_pkg::FN_POP: begin
                if (empty) begin
                    n_out.status = pqft_pkg::ST_EMPTY;
                end else begin
                    n_count        = r_count - CW'(1);
                    n_out.tag_out  = rd_tag;
                    n_out.prio_out = rd_prio;
                end
            end
            pqft_pkg::FN_FIND, pqft_pkg::FN_REMOVE: begin
                if (!found) begin
                    n_out.status = pqft_pkg::ST_NOTFOUND;
                end else begin
                    n_out.tag_out  = rd_tag;
                    n_out.prio_out = rd_prio;
                    if (r_cmd.func == pqft_pkg::FN_REMOVE) begin
                        do_rem  = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            pqft_pkg::FN_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        cnt_ext     = {5'b0, n_count};
        n_out.count = cnt_ext[4:0];
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [15:0] prev_tag;
        logic [7:0]  prev_prio;
        logic [15:0] next_tag;
        logic [7:0]  next_prio;

        assign occ[g] = (CW'(g) < r_count);

        assign cell_ctl[g].load      = finish && do_ins && first[g];
        assign cell_ctl[g].from_prev = finish && do_ins && !below[g] && !first[g];
        assign cell_ctl[g].from_next = finish && do_rem && !below[g];

        if (g == 0) begin : g_head
            assign prev_tag  = r_cmd.tag;
            assign prev_prio = new_prio;
        end else begin : g_mid
            assign prev_tag  = cell_tag[g-1];
            assign prev_prio = cell_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_tag  = cell_tag[g];
            assign next_prio = cell_prio[g];
        end else begin : g_body
            assign next_tag  = cell_tag[g+1];
            assign next_prio = cell_prio[g+1];
        end

        pqft_cell u_cell (
            .i_clk       (i_clk),
            .i_cmp_en    (in_xfer),
            .i_key_tag   (i_in_data.tag),
            .i_key_prio  (i_in_data.prio_in),
            .i_ctl       (cell_ctl[g]),
            .i_new_tag   (r_cmd.tag),
            .i_new_prio  (new_prio),
            .i_prev_tag  (prev_tag),
            .i_prev_prio (prev_prio),
            .i_next_tag  (next_tag),
            .i_next_prio (next_prio),
            .o_tag       (cell_tag[g]),
            .o_prio      (cell_prio[g]),
            .o_le        (le_v[g]),
            .o_eq        (eq_v[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_busy <= 1'b1;
                r_cmd  <= i_in_data;
            end
            if (finish) begin
                r_busy      <= 1'b0;
                r_count     <= n_count;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/pqft_checker.sv =====
// Port-level checker for the priority queue, bound to the top level
`include "priority_queue_fifo_ties_macros.svh"

module pqft_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_stall,
    input logic           i_out_valid,
    input logic           i_out_stall,
    input pqft_pkg::t_out i_out_data
);

    logic in_xfer;
    logic out_held;
    logic out_empty;

    assign in_xfer   = i_in_valid && !i_in_stall;
    assign out_held  = i_out_valid && i_out_stall;
    assign out_empty = i_out_valid && (i_out_data.status == pqft_pkg::ST_EMPTY);

    `PQFT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, i_out_valid && $stable(i_out_data))
    `PQFT_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, i_in_stall)
    `PQFT_ASSERT_NOW(a_result_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(in_xfer, 2))
    `PQFT_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, out_empty, i_out_data.count == 5'd0)

endmodule

bind priority_queue_fifo_ties pqft_checker u_pqft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
